// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, field widths and operation and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Field widths fixed by the interface.
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 2;
  localparam int OCC_BITS      = 5;
  localparam int CFG_BITS      = 5;

  // Default number of cells in the chain.
  localparam int CAPACITY_DEF  = 16;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    FUNC_ENQ   = 2'd0,
    FUNC_DEQ   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_ALTER = 2'd3
  } func_t;

  // Completion status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One request.
  typedef struct packed {
    func_t                    func;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [PAYLOAD_BITS-1:0]  payload;
  } in_t;

  // One result.
  typedef struct packed {
    status_t                  status;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [PAYLOAD_BITS-1:0]  out_payload;
    logic [OCC_BITS-1:0]      occupancy;
  } out_t;

  // One stored entry.
  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  data;
  } entry_t;

  // Control broadcast to the cells of the chain; alter reaches only the head.
  typedef struct packed {
    logic   enq;
    logic   deq;
    logic   alter;
    entry_t ent;
  } cell_ctl_t;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the sorted chain and shifts towards either neighbour.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               valid,
  input  logic               left_take,
  input  spq_pkg::entry_t    left_ent,
  input  spq_pkg::entry_t    right_ent,
  output logic               take,
  output spq_pkg::entry_t    ent
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;
  logic            hit;

  // The new entry belongs at this cell when the cell is empty or holds a
  // strictly larger priority. An overwritten head can break the order, so
  // the flag is carried down the chain and only the first cell that raises
  // it is the insertion point; every cell behind it shifts.
  assign hit  = !valid || (ctl.ent.prio < ent_r.prio);
  assign take = left_take || hit;

  // Next entry: insert, shift right on insert, shift left on removal, overwrite on alter.
  always_comb begin
    ent_nxt = ent_r;
    priority if (ctl.enq) begin
      if (left_take) begin
        ent_nxt = left_ent;
      end else if (hit) begin
        ent_nxt = ctl.ent;
      end
    end else if (ctl.deq) begin
      ent_nxt = right_ent;
    end else if (ctl.alter) begin
      ent_nxt = ctl.ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Stable bounded priority queue kept sorted in a chain of shifting cells.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after request acceptance.
// Throughput: one request per cycle; the chain settles in the accept cycle.
// A result waiting in the output register stalls input only if not taken.
// Reset: the queue is empty and the capacity in use returns to 16, clamped
// to the number of cells. Cell contents are not reset.
module sorted_priority_queue_core #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spq_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output spq_pkg::out_t                 out_data,
  input  logic                          cfg_wr_en,
  input  logic [spq_pkg::CFG_BITS-1:0]  cfg_wr_data
);

  localparam int CW      = $clog2(CAPACITY + 1);
  localparam int CAP_RST = (CAPACITY < 16) ? CAPACITY : 16;

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      cap_r;
  logic [CW-1:0]      cap_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  spq_pkg::out_t      out_data_r;
  spq_pkg::out_t      out_data_nxt;

  logic               accept;
  logic               full;
  logic               empty;
  logic [31:0]        cfg_val;
  logic [31:0]        count_wide;
  spq_pkg::cell_ctl_t ctl;
  spq_pkg::entry_t    ent_w  [CAPACITY];
  logic               take_w [CAPACITY];

  // Handshake: a new request may enter once the pending result leaves.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = (count_r >= cap_r);
  assign empty = (count_r == '0);

  // Broadcast control for the chain.
  always_comb begin
    ctl.enq      = accept && (in_data.func == spq_pkg::FUNC_ENQ) && !full;
    ctl.deq      = accept && (in_data.func == spq_pkg::FUNC_DEQ) && !empty;
    ctl.alter    = accept && (in_data.func == spq_pkg::FUNC_ALTER) && !empty;
    ctl.ent.prio = in_data.priority_req;
    ctl.ent.data = in_data.payload;
  end

  // Cell chain: cell 0 is the head of the queue.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::cell_ctl_t cell_ctl;
    logic               left_take;
    spq_pkg::entry_t    left_ent;
    spq_pkg::entry_t    right_ent;

    // Only the head cell is overwritten by an alter request.
    always_comb begin
      cell_ctl       = ctl;
      cell_ctl.alter = ctl.alter && (i == 0);
    end

    if (i == 0) begin : g_head
      assign left_take = 1'b0;
      assign left_ent  = ctl.ent;
    end else begin : g_body
      assign left_take = take_w[i-1];
      assign left_ent  = ent_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = ent_w[i];
    end else begin : g_mid
      assign right_ent = ent_w[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .valid     (count_r > CW'(i)),
      .left_take (left_take),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .take      (take_w[i]),
      .ent       (ent_w[i])
    );
  end

  // Occupancy after the request.
  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign count_wide = 32'(count_nxt);

  // Result of the accepted request.
  always_comb begin
    out_data_nxt.status       = spq_pkg::ST_OK;
    out_data_nxt.out_priority = '0;
    out_data_nxt.out_payload  = '0;
    out_data_nxt.occupancy    = count_wide[spq_pkg::OCC_BITS-1:0];
    unique case (in_data.func)
      spq_pkg::FUNC_ENQ: begin
        if (full) begin
          out_data_nxt.status = spq_pkg::ST_FULL;
        end
      end
      spq_pkg::FUNC_DEQ, spq_pkg::FUNC_PEEK: begin
        if (empty) begin
          out_data_nxt.status = spq_pkg::ST_EMPTY;
        end else begin
          out_data_nxt.out_priority = ent_w[0].prio;
          out_data_nxt.out_payload  = ent_w[0].data;
        end
      end
      spq_pkg::FUNC_ALTER: begin
        if (empty) begin
          out_data_nxt.status = spq_pkg::ST_EMPTY;
        end
      end
      default: begin
        out_data_nxt.status = spq_pkg::ST_OK;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Capacity in use: zero acts as one, anything above the cell count is
  // clamped to the cell count.
  assign cfg_val = 32'(cfg_wr_data);

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr_en) begin
      if (cfg_val == 32'd0) begin
        cap_nxt = CW'(1);
      end else if (cfg_val > 32'(CAPACITY)) begin
        cap_nxt = CW'(CAPACITY);
      end else begin
        cap_nxt = cfg_val[CW-1:0];
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CW'(CAP_RST);
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
